/* sv/qau_pkg.sv */
// Shared types, operation codes and the Hamilton product table of the quaternion unit.
package qau_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 28;

    typedef enum logic [2:0] {
        FN_ADD       = 3'd0,
        FN_SUB       = 3'd1,
        FN_MUL       = 3'd2,
        FN_SCALE     = 3'd3,
        FN_CONJ      = 3'd4,
        FN_NORMALIZE = 3'd5,
        FN_NORM      = 3'd6
    } t_func;

    typedef logic [1:0] t_idx;

    // For result lane i and term k: which component of A, which of B, and whether the
    // product is subtracted.
    localparam t_idx HAM_A [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };

    localparam t_idx HAM_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };

    localparam logic HAM_N [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1}
    };

endpackage

/* sv/qau_front.sv */
// Front end: product array, term accumulation and saturation of the direct operations.
module qau_front #(
    parameter int W = qau_pkg::COMP_WIDTH_DEF,
    parameter int F = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2:0]          i_func,
    input  logic signed [W-1:0] i_a [4],
    input  logic signed [W-1:0] i_b [4],
    input  logic signed [W-1:0] i_scale,
    output logic [2:0]          o_vld,
    output logic [2:0]          o_func,
    output logic [W-1:0]        o_r [4],
    output logic                o_ovf,
    output logic [3:0]          o_sign,
    output logic [W-1:0]        o_mag [4],
    output logic [2*W:0]        o_sq
);

    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 2;

    qau_pkg::t_func fn;
    assign fn = qau_pkg::t_func'(i_func);

    logic signed [W-1:0]  op_a [4][4];
    logic signed [W-1:0]  op_b [4][4];
    logic signed [W:0]    ea [4];
    logic signed [W:0]    eb [4];
    logic signed [W:0]    qs [4];
    logic [3:0]           qovf;
    logic signed [PW-1:0] n_prod [4][4];
    logic [W-1:0]         n_q [4];
    logic [3:0]           n_sign;
    logic [W-1:0]         n_mag [4];

    // Stage 1 registers.
    logic                 r_v1;
    logic signed [PW-1:0] r_prod [4][4];
    logic [W-1:0]         r_q1 [4];
    logic                 r_qovf1;
    qau_pkg::t_func       r_func1;
    logic [3:0]           r_sign1;
    logic [W-1:0]         r_mag1 [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                case (fn)
                    qau_pkg::FN_MUL: begin
                        op_a[i][k] = i_a[qau_pkg::HAM_A[i][k]];
                        op_b[i][k] = i_b[qau_pkg::HAM_B[i][k]];
                    end
                    qau_pkg::FN_SCALE: begin
                        op_a[i][k] = i_a[i];
                        op_b[i][k] = (k == 0) ? i_scale : '0;
                    end
                    default: begin
                        // Squares of A, used by the norm operations.
                        op_a[i][k] = i_a[k];
                        op_b[i][k] = i_a[k];
                    end
                endcase
                n_prod[i][k] = op_a[i][k] * op_b[i][k];
            end
            ea[i] = {i_a[i][W-1], i_a[i]};
            eb[i] = {i_b[i][W-1], i_b[i]};
            case (fn)
                qau_pkg::FN_ADD:  qs[i] = ea[i] + eb[i];
                qau_pkg::FN_SUB:  qs[i] = ea[i] - eb[i];
                qau_pkg::FN_CONJ: qs[i] = (i == 0) ? ea[i] : -ea[i];
                default:          qs[i] = '0;
            endcase
            qovf[i]   = qs[i][W] ^ qs[i][W-1];
            n_q[i]    = qovf[i] ? {qs[i][W], {(W-1){~qs[i][W]}}} : qs[i][W-1:0];
            n_sign[i] = i_a[i][W-1];
            n_mag[i]  = n_sign[i] ? -i_a[i] : i_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_q1    <= n_q;
            r_qovf1 <= |qovf;
            r_func1 <= fn;
            r_sign1 <= n_sign;
            r_mag1  <= n_mag;
        end
    end

    // Stage 2: signed sum of the four terms of each lane.
    logic signed [AW-1:0] n_acc [4];
    logic                 r_v2;
    logic signed [AW-1:0] r_acc [4];
    logic [W-1:0]         r_q2 [4];
    logic                 r_qovf2;
    qau_pkg::t_func       r_func2;
    logic [3:0]           r_sign2;
    logic [W-1:0]         r_mag2 [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_acc[i] = '0;
            for (int k = 0; k < 4; k++) begin
                if (r_func1 == qau_pkg::FN_MUL && qau_pkg::HAM_N[i][k]) begin
                    n_acc[i] = n_acc[i] - AW'(r_prod[i][k]);
                end else begin
                    n_acc[i] = n_acc[i] + AW'(r_prod[i][k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc   <= n_acc;
            r_q2    <= r_q1;
            r_qovf2 <= r_qovf1;
            r_func2 <= r_func1;
            r_sign2 <= r_sign1;
            r_mag2  <= r_mag1;
        end
    end

    // Stage 3: drop the fraction bits and saturate, or pick the direct result.
    logic signed [AW-1:0] sh [4];
    logic [3:0]           sovf;
    logic [W-1:0]         n_r [4];
    logic                 n_ovf;
    logic                 r_v3;
    logic [W-1:0]         r_r3 [4];
    logic                 r_ovf3;
    qau_pkg::t_func       r_func3;
    logic [3:0]           r_sign3;
    logic [W-1:0]         r_mag3 [4];
    logic [2*W:0]         r_sq3;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sh[i]   = r_acc[i] >>> F;
            sovf[i] = !((&sh[i][AW-1:W-1]) || !(|sh[i][AW-1:W-1]));
        end
        n_ovf = 1'b0;
        case (r_func2)
            qau_pkg::FN_MUL, qau_pkg::FN_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    n_r[i] = sovf[i] ? {sh[i][AW-1], {(W-1){~sh[i][AW-1]}}} : sh[i][W-1:0];
                end
                n_ovf = |sovf;
            end
            qau_pkg::FN_ADD, qau_pkg::FN_SUB, qau_pkg::FN_CONJ: begin
                n_r   = r_q2;
                n_ovf = r_qovf2;
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    n_r[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r3    <= n_r;
            r_ovf3  <= n_ovf;
            r_func3 <= r_func2;
            r_sign3 <= r_sign2;
            r_mag3  <= r_mag2;
            r_sq3   <= r_acc[0][2*W:0];
        end
    end

    assign o_vld  = {r_v3, r_v2, r_v1};
    assign o_func = r_func3;
    assign o_r    = r_r3;
    assign o_ovf  = r_ovf3;
    assign o_sign = r_sign3;
    assign o_mag  = r_mag3;
    assign o_sq   = r_sq3;

endmodule

/* sv/qau_sqrt_stage.sv */
// One stage of the square root pipeline: decides a single bit of the root.
module qau_sqrt_stage #(
    parameter int W      = qau_pkg::COMP_WIDTH_DEF,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [2*W:0]      i_rem,
    input  logic [W:0]        i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [2*W:0]      o_rem,
    output logic [W:0]        o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int TW = 2 * W + 3;

    logic [TW-1:0]     trial;
    logic [TW-1:0]     rem_x;
    logic              take;
    logic [2*W:0]      n_rem;
    logic [W:0]        n_root;
    logic              r_vld;
    logic [2*W:0]      r_rem;
    logic [W:0]        r_root;
    logic [SIDE_W-1:0] r_side;

    // The remainder holds the square minus the square of the root so far; setting
    // this bit costs twice the root shifted up plus the square of the bit.
    always_comb begin
        trial  = (TW'(i_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        rem_x  = TW'(i_rem);
        take   = trial <= rem_x;
        n_rem  = take ? i_rem - trial[2*W:0] : i_rem;
        n_root = i_root;
        if (take) begin
            n_root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

/* sv/qau_div_stage.sv */
// One stage of the normalising divider: one quotient bit for each of the four lanes.
module qau_div_stage #(
    parameter int W      = qau_pkg::COMP_WIDTH_DEF,
    parameter int F      = qau_pkg::FRAC_BITS_DEF,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [W:0]        i_n,
    input  logic [W+1:0]      i_rem [4],
    input  logic [F:0]        i_q [4],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [W:0]        o_n,
    output logic [W+1:0]      o_rem [4],
    output logic [F:0]        o_q [4],
    output logic [SIDE_W-1:0] o_side
);

    logic [W+1:0]      nx;
    logic [3:0]        ge;
    logic [W+1:0]      diff [4];
    logic [W+1:0]      n_rem [4];
    logic [F:0]        n_q [4];
    logic              r_vld;
    logic [W:0]        r_n;
    logic [W+1:0]      r_rem [4];
    logic [F:0]        r_q [4];
    logic [SIDE_W-1:0] r_side;

    // The partial remainder stays below the divisor after each step, so one
    // compare and subtract gives the bit; the next dividend bit is always zero.
    always_comb begin
        nx = (W+2)'(i_n);
        for (int l = 0; l < 4; l++) begin
            ge[l]       = i_rem[l] >= nx;
            diff[l]     = ge[l] ? i_rem[l] - nx : i_rem[l];
            n_rem[l]    = {diff[l][W:0], 1'b0};
            n_q[l]      = i_q[l];
            n_q[l][BIT] = ge[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= i_n;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

/* sv/quaternion_arithmetic_unit.sv */
// Every operation takes the same path. Throughput: one item per cycle unless the output
// stalls; the square root and divider are fully pipelined, one bit per stage, so their
// depth (COMP_WIDTH + 1 and FRAC_BITS + 1 stages) sets the latency.
// While a result waits at the output, the whole pipeline holds and no input is taken.
// Reset (synchronous, active low) clears every stage valid bit; data registers are not reset.
module quaternion_arithmetic_unit #(
    parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_func,
    input  logic signed [COMP_WIDTH-1:0] i_a_w,
    input  logic signed [COMP_WIDTH-1:0] i_a_x,
    input  logic signed [COMP_WIDTH-1:0] i_a_y,
    input  logic signed [COMP_WIDTH-1:0] i_a_z,
    input  logic signed [COMP_WIDTH-1:0] i_b_w,
    input  logic signed [COMP_WIDTH-1:0] i_b_x,
    input  logic signed [COMP_WIDTH-1:0] i_b_y,
    input  logic signed [COMP_WIDTH-1:0] i_b_z,
    input  logic signed [COMP_WIDTH-1:0] i_scale,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COMP_WIDTH-1:0] o_r_w,
    output logic signed [COMP_WIDTH-1:0] o_r_x,
    output logic signed [COMP_WIDTH-1:0] o_r_y,
    output logic signed [COMP_WIDTH-1:0] o_r_z,
    output logic [COMP_WIDTH-2:0]        o_norm_out,
    output logic                         o_overflow,
    output logic                         o_zero_norm
);

    localparam int W       = COMP_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int NR      = W + 1;
    localparam int ND      = F + 1;
    localparam int SQ_SIDE = 8 * W + 8;
    localparam int DV_SIDE = 4 * W + 8;
    localparam int QW      = ((F + 1 > W) ? F + 1 : W) + 1;
    localparam int DEPTH   = 3 + NR + ND + 1;
    localparam int CW      = $clog2(DEPTH + 1);

    localparam logic [W:0]    NMAX = {2'b00, {(W-1){1'b1}}};
    localparam logic [QW-1:0] POSM = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0] NEGM = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic en;
    logic r_out_vld;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    logic signed [W-1:0] a_arr [4];
    logic signed [W-1:0] b_arr [4];

    assign a_arr = '{i_a_w, i_a_x, i_a_y, i_a_z};
    assign b_arr = '{i_b_w, i_b_x, i_b_y, i_b_z};

    logic [2:0]   f_vld;
    logic [2:0]   f_func;
    logic [W-1:0] f_r [4];
    logic         f_ovf;
    logic [3:0]   f_sign;
    logic [W-1:0] f_mag [4];
    logic [2*W:0] f_sq;

    qau_front #(.W(W), .F(F)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_func  (i_func),
        .i_a     (a_arr),
        .i_b     (b_arr),
        .i_scale (i_scale),
        .o_vld   (f_vld),
        .o_func  (f_func),
        .o_r     (f_r),
        .o_ovf   (f_ovf),
        .o_sign  (f_sign),
        .o_mag   (f_mag),
        .o_sq    (f_sq)
    );

    // Square root pipeline, most significant root bit first.
    logic               sq_vld  [NR+1];
    logic [2*W:0]       sq_rem  [NR+1];
    logic [W:0]         sq_root [NR+1];
    logic [SQ_SIDE-1:0] sq_side [NR+1];

    assign sq_vld[0]  = f_vld[2];
    assign sq_rem[0]  = f_sq;
    assign sq_root[0] = '0;
    assign sq_side[0] = {f_func, f_ovf, f_sign, f_r[0], f_r[1], f_r[2], f_r[3],
                         f_mag[0], f_mag[1], f_mag[2], f_mag[3]};

    for (genvar j = 0; j < NR; j++) begin : g_sqrt
        qau_sqrt_stage #(.W(W), .BIT(NR - 1 - j), .SIDE_W(SQ_SIDE)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[j]),
            .i_rem   (sq_rem[j]),
            .i_root  (sq_root[j]),
            .i_side  (sq_side[j]),
            .o_vld   (sq_vld[j+1]),
            .o_rem   (sq_rem[j+1]),
            .o_root  (sq_root[j+1]),
            .o_side  (sq_side[j+1])
        );
    end

    // When W + 1 exceeds 64, a root too wide for W bits becomes the largest W-bit value.
    logic [W:0] n_clamp;

    if (W + 1 > 64) begin : g_clamp
        assign n_clamp = sq_root[NR][W] ? {1'b0, {W{1'b1}}} : sq_root[NR];
    end else begin : g_noclamp
        assign n_clamp = sq_root[NR];
    end

    // Divider pipeline; each lane starts from the magnitude of its component of A.
    logic               dv_vld  [ND+1];
    logic [W:0]         dv_n    [ND+1];
    logic [W+1:0]       dv_rem  [ND+1][4];
    logic [F:0]         dv_q    [ND+1][4];
    logic [DV_SIDE-1:0] dv_side [ND+1];

    assign dv_vld[0]  = sq_vld[NR];
    assign dv_n[0]    = n_clamp;
    assign dv_side[0] = sq_side[NR][SQ_SIDE-1:4*W];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            dv_rem[0][l] = (W+2)'(sq_side[NR][(3-l)*W +: W]);
            dv_q[0][l]   = '0;
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        qau_div_stage #(.W(W), .F(F), .BIT(F - j), .SIDE_W(DV_SIDE)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[j]),
            .i_n     (dv_n[j]),
            .i_rem   (dv_rem[j]),
            .i_q     (dv_q[j]),
            .i_side  (dv_side[j]),
            .o_vld   (dv_vld[j+1]),
            .o_n     (dv_n[j+1]),
            .o_rem   (dv_rem[j+1]),
            .o_q     (dv_q[j+1]),
            .o_side  (dv_side[j+1])
        );
    end

    // Output stage: sign and saturate the quotients, saturate the norm, select by operation.
    qau_pkg::t_func fin_func;
    logic           fin_qovf;
    logic [3:0]     fin_sign;
    logic [W:0]     fin_n;
    logic           n_big;
    logic [W-2:0]   nsat;
    logic [QW-1:0]  qx [4];
    logic [QW-1:0]  negq [4];
    logic [3:0]     qov;
    logic [W-1:0]   dq [4];
    logic [W-1:0]   n_out_r [4];
    logic [W-2:0]   n_out_norm;
    logic           n_out_ovf;
    logic           n_out_zn;

    always_comb begin
        fin_func = qau_pkg::t_func'(dv_side[ND][4*W+5 +: 3]);
        fin_qovf = dv_side[ND][4*W+4];
        fin_sign = dv_side[ND][4*W +: 4];
        fin_n    = dv_n[ND];
        n_big    = fin_n > NMAX;
        nsat     = n_big ? NMAX[W-2:0] : fin_n[W-2:0];
        for (int l = 0; l < 4; l++) begin
            qx[l]   = QW'(dv_q[ND][l]);
            negq[l] = -qx[l];
            if (fin_sign[l]) begin
                qov[l] = qx[l] > NEGM;
                dq[l]  = qov[l] ? {1'b1, {(W-1){1'b0}}} : negq[l][W-1:0];
            end else begin
                qov[l] = qx[l] > POSM;
                dq[l]  = qov[l] ? {1'b0, {(W-1){1'b1}}} : qx[l][W-1:0];
            end
        end
        for (int l = 0; l < 4; l++) begin
            n_out_r[l] = '0;
        end
        n_out_norm = '0;
        n_out_ovf  = 1'b0;
        n_out_zn   = 1'b0;
        case (fin_func)
            qau_pkg::FN_ADD, qau_pkg::FN_SUB, qau_pkg::FN_MUL, qau_pkg::FN_SCALE,
            qau_pkg::FN_CONJ: begin
                for (int l = 0; l < 4; l++) begin
                    n_out_r[l] = dv_side[ND][(3-l)*W +: W];
                end
                n_out_ovf = fin_qovf;
            end
            qau_pkg::FN_NORMALIZE: begin
                if (fin_n == '0) begin
                    n_out_zn = 1'b1;
                end else begin
                    n_out_r    = dq;
                    n_out_norm = nsat;
                    n_out_ovf  = n_big || (|qov);
                end
            end
            qau_pkg::FN_NORM: begin
                n_out_norm = nsat;
                n_out_ovf  = n_big;
            end
            default: begin
                n_out_ovf = 1'b0;
            end
        endcase
    end

    logic [W-1:0] r_out_r [4];
    logic [W-2:0] r_out_norm;
    logic         r_out_ovf;
    logic         r_out_zn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_r    <= n_out_r;
            r_out_norm <= n_out_norm;
            r_out_ovf  <= n_out_ovf;
            r_out_zn   <= n_out_zn;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_r_w       = r_out_r[0];
    assign o_r_x       = r_out_r[1];
    assign o_r_y       = r_out_r[2];
    assign o_r_z       = r_out_r[3];
    assign o_norm_out  = r_out_norm;
    assign o_overflow  = r_out_ovf;
    assign o_zero_norm = r_out_zn;

    // Occupancy bookkeeping: every transfer in adds an item, every transfer out removes one.
    logic [DEPTH-1:0] all_vld;
    logic [CW-1:0]    r_inflt;

    always_comb begin
        all_vld[2:0] = f_vld;
        for (int j = 0; j < NR; j++) begin
            all_vld[3+j] = sq_vld[j+1];
        end
        for (int j = 0; j < ND; j++) begin
            all_vld[3+NR+j] = dv_vld[j+1];
        end
        all_vld[DEPTH-1] = r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflt <= '0;
        end else begin
            r_inflt <= r_inflt + CW'(i_in_valid && o_in_ready) - CW'(o_out_valid && i_out_ready);
        end
    end

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(all_vld) == int'(r_inflt))
        else $error("stage valid bits disagree with the transfer count");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_norm |-> !o_overflow && o_norm_out == '0 && o_r_w == '0
            && o_r_x == '0 && o_r_y == '0 && o_r_z == '0)
        else $error("zero-norm result carries data or overflow");

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

/* tb/qau_checker.sv */
// Checker for the quaternion unit: predicts each result from accepted inputs and compares.
module qau_checker #(
    parameter int CW = 32,
    parameter int FB = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [2:0]           i_func,
    input  logic signed [CW-1:0] i_a_w,
    input  logic signed [CW-1:0] i_a_x,
    input  logic signed [CW-1:0] i_a_y,
    input  logic signed [CW-1:0] i_a_z,
    input  logic signed [CW-1:0] i_b_w,
    input  logic signed [CW-1:0] i_b_x,
    input  logic signed [CW-1:0] i_b_y,
    input  logic signed [CW-1:0] i_b_z,
    input  logic signed [CW-1:0] i_scale,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [CW-1:0] i_r_w,
    input  logic signed [CW-1:0] i_r_x,
    input  logic signed [CW-1:0] i_r_y,
    input  logic signed [CW-1:0] i_r_z,
    input  logic [CW-2:0]        i_norm_out,
    input  logic                 i_overflow,
    input  logic                 i_zero_norm,
    output int                   o_errors,
    output int                   o_pending
);

    typedef logic signed [CW-1:0] t_comp;
    typedef struct packed {
        t_comp [3:0]   r;
        logic [CW-2:0] norm;
        logic          ovf;
        logic          zn;
    } t_quat_res;

    t_quat_res expected_q[$];

    function automatic string comp_name(input int i);
        case (i)
            0:       return "r_w";
            1:       return "r_x";
            2:       return "r_y";
            default: return "r_z";
        endcase
    endfunction

    // Clamp a wide signed value to the component range.
    function automatic t_comp clamp(input logic signed [191:0] v, inout logic ovf);
        logic signed [191:0] hi, lo;
        hi = (192'sd1 <<< (CW - 1)) - 1;
        lo = -(192'sd1 <<< (CW - 1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic logic [191:0] int_sqrt(input logic [191:0] s);
        logic [191:0] root, c;
        root = '0;
        for (int bitn = 63; bitn >= 0; bitn--) begin
            c = root | (192'd1 << bitn);
            if (c * c <= s) root = c;
        end
        return root;
    endfunction

    function automatic t_quat_res quat_result(input logic [2:0] fn, input t_comp a[4],
                                               input t_comp b[4], input t_comp s);
        t_quat_res res;
        logic signed [191:0] acc, p, sq, num, q;
        logic [191:0] n;
        logic ovf;
        ovf = 1'b0;
        res = '0;
        sq = '0;
        case (fn)
            qau_pkg::FN_ADD, qau_pkg::FN_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    acc = (fn == qau_pkg::FN_ADD) ? 192'(a[i]) + 192'(b[i])
                                                  : 192'(a[i]) - 192'(b[i]);
                    res.r[i] = clamp(acc, ovf);
                end
            end
            qau_pkg::FN_MUL: begin
                for (int i = 0; i < 4; i++) begin
                    acc = '0;
                    for (int k = 0; k < 4; k++) begin
                        p = 192'(a[qau_pkg::HAM_A[i][k]]) * 192'(b[qau_pkg::HAM_B[i][k]]);
                        acc = qau_pkg::HAM_N[i][k] ? acc - p : acc + p;
                    end
                    res.r[i] = clamp(acc >>> FB, ovf);
                end
            end
            qau_pkg::FN_SCALE: begin
                for (int i = 0; i < 4; i++)
                    res.r[i] = clamp((192'(a[i]) * 192'(s)) >>> FB, ovf);
            end
            qau_pkg::FN_CONJ: begin
                res.r[0] = a[0];
                for (int i = 1; i < 4; i++) res.r[i] = clamp(-192'(a[i]), ovf);
            end
            qau_pkg::FN_NORMALIZE, qau_pkg::FN_NORM: begin
                for (int i = 0; i < 4; i++) sq += 192'(a[i]) * 192'(a[i]);
                n = int_sqrt(sq);
                if (n > (192'd1 << (CW - 1)) - 1) begin
                    res.norm = '1;
                    ovf = 1'b1;
                end else begin
                    res.norm = n[CW-2:0];
                end
                if (fn == qau_pkg::FN_NORMALIZE) begin
                    if (n == 0) begin
                        res.zn = 1'b1;
                        res.norm = '0;
                        ovf = 1'b0;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            // Signed division truncates toward zero, as required.
                            num = 192'(a[i]) <<< FB;
                            q = num / $signed(n);
                            res.r[i] = clamp(q, ovf);
                        end
                    end
                end
            end
            default: ;
        endcase
        res.ovf = ovf;
        return res;
    endfunction

    initial o_errors = 0;
    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_comp a[4], b[4];
        t_quat_res want, got;
        int bad;
        bad = 0;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            a = '{i_a_w, i_a_x, i_a_y, i_a_z};
            b = '{i_b_w, i_b_x, i_b_y, i_b_z};
            expected_q.push_back(quat_result(i_func, a, b, i_scale));
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got.r[0] = i_r_w;
            got.r[1] = i_r_x;
            got.r[2] = i_r_y;
            got.r[3] = i_r_z;
            got.norm = i_norm_out;
            got.ovf = i_overflow;
            got.zn = i_zero_norm;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                bad++;
            end else begin
                want = expected_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (got.r[i] !== want.r[i]) begin
                        $error("%s: expected %0d, got %0d", comp_name(i), want.r[i],
                               got.r[i]);
                        bad++;
                    end
                if (got.norm !== want.norm) begin
                    $error("norm_out: expected %0d, got %0d", want.norm, got.norm);
                    bad++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
                    bad++;
                end
                if (got.zn !== want.zn) begin
                    $error("zero_norm: expected %0b, got %0b", want.zn, got.zn);
                    bad++;
                end
            end
        end
        o_errors <= o_errors + bad;
    end
endmodule

/* tb/tb_quaternion_arithmetic_unit.sv */
// Top of the quaternion unit testbench: stimulus, output stalls and the verdict.
module tb_quaternion_arithmetic_unit;

    localparam int CW = qau_pkg::COMP_WIDTH_DEF;
    localparam int FB = qau_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = CW + FB + 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0, out_ready = 1'b0;
    logic in_ready, out_valid;
    logic [2:0] func = qau_pkg::FN_ADD;
    logic signed [CW-1:0] opnd[9];
    logic signed [CW-1:0] r_w, r_x, r_y, r_z;
    logic [CW-2:0] norm_out;
    logic ovf, zn;
    int errors, pending;
    bit stim_done = 1'b0;

    initial for (int i = 0; i < 9; i++) opnd[i] = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    quaternion_arithmetic_unit #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_func(func), .i_a_w(opnd[0]), .i_a_x(opnd[1]), .i_a_y(opnd[2]), .i_a_z(opnd[3]),
        .i_b_w(opnd[4]), .i_b_x(opnd[5]), .i_b_y(opnd[6]), .i_b_z(opnd[7]),
        .i_scale(opnd[8]), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_r_w(r_w), .o_r_x(r_x), .o_r_y(r_y), .o_r_z(r_z), .o_norm_out(norm_out),
        .o_overflow(ovf), .o_zero_norm(zn)
    );

    qau_checker #(.CW(CW), .FB(FB)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_func(func), .i_a_w(opnd[0]), .i_a_x(opnd[1]), .i_a_y(opnd[2]), .i_a_z(opnd[3]),
        .i_b_w(opnd[4]), .i_b_x(opnd[5]), .i_b_y(opnd[6]), .i_b_z(opnd[7]),
        .i_scale(opnd[8]), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_r_w(r_w), .i_r_x(r_x), .i_r_y(r_y), .i_r_z(r_z), .i_norm_out(norm_out),
        .i_overflow(ovf), .i_zero_norm(zn), .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Extremes, small, mid-range and random words, so saturation and rounding come often.
    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CW - 1){1'b0}}};
            1: return {1'b0, {(CW - 1){1'b1}}};
            2: return CW'($signed($urandom_range(0, 2 ** 16)) - 32768);
            3: return CW'($signed($urandom_range(0, 2 ** 30)) - (2 ** 29));
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input logic [2:0] fn, input logic signed [CW-1:0] v[9]);
        in_valid <= 1'b1;
        func <= fn;
        for (int i = 0; i < 9; i++) opnd[i] <= v[i];
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Output side: random stalls, plus one long hold-off while the sender keeps going.
    initial begin
        int g;
        @(posedge i_rst_n);
        repeat (300) @(posedge i_clk);
        out_ready <= 1'b0;
        repeat (400) @(posedge i_clk);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic signed [CW-1:0] v[9];
        logic signed [CW-1:0] maxv, minv, one;
        maxv = {1'b0, {(CW - 1){1'b1}}};
        minv = {1'b1, {(CW - 1){1'b0}}};
        one = CW'(1) <<< FB;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each operation at the extremes, zero-norm normalize, unused code 7.
        for (int fn = 0; fn < 8; fn++) begin
            for (int i = 0; i < 9; i++) v[i] = maxv;
            send(fn[2:0], v);
            for (int i = 0; i < 9; i++) v[i] = minv;
            send(fn[2:0], v);
            for (int i = 0; i < 9; i++) v[i] = (i % 2) ? one : -one;
            send(fn[2:0], v);
        end
        for (int i = 0; i < 9; i++) v[i] = '0;
        send(qau_pkg::FN_NORMALIZE, v);

        for (int n = 0; n < 1100; n++) begin
            for (int i = 0; i < 9; i++) v[i] = rand_comp();
            if ($urandom_range(0, 19) == 0) for (int i = 0; i < 4; i++) v[i] = '0;
            send(3'($urandom_range(0, 7)), v);
            send_gap();
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("tb_quaternion_arithmetic_unit: clean");
        else
            $display("tb_quaternion_arithmetic_unit: errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_quaternion_arithmetic_unit: errors");
        $finish;
    end
endmodule

/* quaternion_arithmetic_unit.f */
sv/qau_pkg.sv
sv/qau_front.sv
sv/qau_sqrt_stage.sv
sv/qau_div_stage.sv
sv/quaternion_arithmetic_unit.sv
tb/qau_checker.sv
tb/tb_quaternion_arithmetic_unit.sv
